/* src/rgpe_pkg.sv */
// ----------------------------------------------------------------------------
// rgpe_pkg: shared types and constants of the radar grid pixel extractor
// Field widths, descriptor codes, register indexes and the front/back record.
// ----------------------------------------------------------------------------
package rgpe_pkg;

  localparam int MaxDimension = 4096;
  localparam int DimW   = 13;
  localparam int CountW = 25;
  localparam int ValW   = 40;
  localparam int ThrW   = 24;

  localparam logic signed [ValW-1:0] QMax   = {1'b0, {(ValW-1){1'b1}}};
  localparam logic signed [ValW-1:0] QMin   = {1'b1, {(ValW-1){1'b0}}};
  localparam logic signed [ValW-1:0] NodataQ = -40'sd2559744;

  localparam logic signed [ThrW-1:0] UndetectReset = -24'sd10240;
  localparam logic signed [ThrW-1:0] VisibleReset  = 24'sd1408;
  localparam logic signed [ThrW-1:0] StrongReset   = 24'sd8960;

  typedef enum logic [1:0] {
    REG_UNDETECT = 2'd0,
    REG_VISIBLE  = 2'd1,
    REG_STRONG   = 2'd2
  } reg_idx_t;

  // descriptor X/Y codes (F is always 0 for these)
  localparam logic [5:0] XRepl = 6'd31;
  localparam logic [7:0] YRepl = 8'd192;
  localparam logic [5:0] XGrid = 6'd21;
  localparam logic [7:0] YProb = 8'd120;
  localparam logic [7:0] YRefl = 8'd1;
  localparam logic [5:0] XDim  = 6'd30;
  localparam logic [7:0] YRows = 8'd21;
  localparam logic [7:0] YCols = 8'd22;

  // pixel request handed from the front to the back
  typedef struct packed {
    logic                   kind;   // 0 reflectivity, 1 probability
    logic signed [ValW-1:0] value;
    logic                   miss;
    logic [CountW-1:0]      expected;
  } pix_req_t;

  typedef struct packed {
    logic                   grid_kind;
    logic signed [ValW-1:0] pixel_value;
    logic                   is_nodata;
    logic                   is_last;
    logic [CountW-1:0]      pixel_number;
    logic [CountW-1:0]      missing_total;
    logic [CountW-1:0]      undetect_total;
    logic [CountW-1:0]      visible_total;
    logic [CountW-1:0]      strong_total;
    logic signed [ValW-1:0] lowest_seen;
    logic signed [ValW-1:0] highest_seen;
  } pix_res_t;

endpackage

/* src/rgpe_if.sv */
// ----------------------------------------------------------------------------
// rgpe channel interfaces
// Valid/ready channels for input items, results and register writes.
// ----------------------------------------------------------------------------
interface rgpe_in_if;
  logic                           valid;
  logic                           ready;
  logic                           is_element;
  logic [1:0]                     descriptor_f;
  logic [5:0]                     descriptor_x;
  logic [7:0]                     descriptor_y;
  logic signed [rgpe_pkg::ValW-1:0] sample_value;
  logic                           value_missing;
  modport source (output valid, is_element, descriptor_f, descriptor_x, descriptor_y,
                  sample_value, value_missing, input ready);
  modport sink   (input valid, is_element, descriptor_f, descriptor_x, descriptor_y,
                  sample_value, value_missing, output ready);
endinterface

interface rgpe_out_if;
  logic                           valid;
  logic                           ready;
  logic                           grid_kind;
  logic signed [rgpe_pkg::ValW-1:0] pixel_value;
  logic                           is_nodata;
  logic                           is_last;
  logic [rgpe_pkg::CountW-1:0]    pixel_number;
  logic [rgpe_pkg::CountW-1:0]    missing_total;
  logic [rgpe_pkg::CountW-1:0]    undetect_total;
  logic [rgpe_pkg::CountW-1:0]    visible_total;
  logic [rgpe_pkg::CountW-1:0]    strong_total;
  logic signed [rgpe_pkg::ValW-1:0] lowest_seen;
  logic signed [rgpe_pkg::ValW-1:0] highest_seen;
  modport source (output valid, grid_kind, pixel_value, is_nodata, is_last, pixel_number,
                  missing_total, undetect_total, visible_total, strong_total,
                  lowest_seen, highest_seen, input ready);
  modport sink   (input valid, grid_kind, pixel_value, is_nodata, is_last, pixel_number,
                  missing_total, undetect_total, visible_total, strong_total,
                  lowest_seen, highest_seen, output ready);
endinterface

interface rgpe_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [1:0]                     index;
  logic [rgpe_pkg::ThrW-1:0]      data;
  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* src/rgpe_front.sv */
// ----------------------------------------------------------------------------
// rgpe_front: descriptor classifier
// Tracks grid header, arming and capture flags; emits pixel requests.
// ----------------------------------------------------------------------------
module rgpe_front (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      acc,
  input  logic                      is_element,
  input  logic [1:0]                f,
  input  logic [5:0]                x,
  input  logic [7:0]                y,
  input  logic signed [rgpe_pkg::ValW-1:0] v,
  input  logic                      miss,
  output logic                      req_valid,
  output rgpe_pkg::pix_req_t        req
);

  logic [rgpe_pkg::DimW-1:0]   rows_r, rows_nxt, cols_r, cols_nxt;
  logic [rgpe_pkg::CountW-1:0] exp_r, exp_nxt;
  logic                        arm_r, arm_nxt, cp_r, cp_nxt, cr_r, cr_nxt;
  logic [rgpe_pkg::CountW-1:0] pcnt_r, pcnt_nxt, rcnt_r, rcnt_nxt;
  logic [rgpe_pkg::DimW-1:0]   dim;
  logic signed [rgpe_pkg::ValW-9:0] ipart;
  logic is_rows, is_cols, is_repl, is_prob, is_refl, f0;

  assign ipart = v[rgpe_pkg::ValW-1:8];
  assign f0 = (f == 2'd0);
  assign is_rows = f0 && x == rgpe_pkg::XDim && y == rgpe_pkg::YRows;
  assign is_cols = f0 && x == rgpe_pkg::XDim && y == rgpe_pkg::YCols;
  assign is_repl = f0 && x == rgpe_pkg::XRepl && y == rgpe_pkg::YRepl;
  assign is_prob = f0 && x == rgpe_pkg::XGrid && y == rgpe_pkg::YProb;
  assign is_refl = f0 && x == rgpe_pkg::XGrid && y == rgpe_pkg::YRefl;

  // truncation toward zero of a non-negative value equals the floor shift
  always_comb begin
    if (v < 0) dim = '0;
    else if (ipart > 32'(rgpe_pkg::MaxDimension)) dim = rgpe_pkg::DimW'(rgpe_pkg::MaxDimension);
    else dim = ipart[rgpe_pkg::DimW-1:0];
  end

  always_comb begin
    rows_nxt = rows_r; cols_nxt = cols_r; exp_nxt = exp_r;
    arm_nxt = arm_r; cp_nxt = cp_r; cr_nxt = cr_r;
    pcnt_nxt = pcnt_r; rcnt_nxt = rcnt_r;
    req_valid = 1'b0;
    req.kind = is_prob; req.value = v; req.miss = miss; req.expected = exp_nxt;
    if (acc && is_element) begin
      if (is_rows && !miss) rows_nxt = dim;
      if (is_cols && !miss) cols_nxt = dim;
      // operands widened first: 4096 x 4096 needs the full count width
      if (exp_r == '0 && rows_nxt != '0 && cols_nxt != '0)
        exp_nxt = rgpe_pkg::CountW'(rows_nxt) * rgpe_pkg::CountW'(cols_nxt);
      req.expected = exp_nxt;
      if (is_repl && !miss) begin
        arm_nxt = (v >= 0) && exp_nxt != '0 && ipart == 32'(exp_nxt);
      end else begin
        if (arm_r) begin
          arm_nxt = 1'b0;
          if (is_prob) cp_nxt = 1'b1;
          else if (is_refl) cr_nxt = 1'b1;
        end
        if (cp_nxt && is_prob) begin
          if (pcnt_r >= exp_nxt) cp_nxt = 1'b0;
          else begin
            pcnt_nxt = pcnt_r + 1'b1;
            req_valid = 1'b1;
            if (pcnt_nxt == exp_nxt) cp_nxt = 1'b0;
          end
        end else if (cr_nxt && is_refl) begin
          if (rcnt_r >= exp_nxt) cr_nxt = 1'b0;
          else begin
            rcnt_nxt = rcnt_r + 1'b1;
            req_valid = 1'b1;
            if (rcnt_nxt == exp_nxt) cr_nxt = 1'b0;
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r <= '0; cols_r <= '0; exp_r <= '0;
      arm_r <= 1'b0; cp_r <= 1'b0; cr_r <= 1'b0;
      pcnt_r <= '0; rcnt_r <= '0;
    end else begin
      rows_r <= rows_nxt; cols_r <= cols_nxt; exp_r <= exp_nxt;
      arm_r <= arm_nxt; cp_r <= cp_nxt; cr_r <= cr_nxt;
      pcnt_r <= pcnt_nxt; rcnt_r <= rcnt_nxt;
    end
  end

endmodule

/* src/rgpe_fifo.sv */
// ----------------------------------------------------------------------------
// rgpe_fifo: four-entry request queue between front and back
// ----------------------------------------------------------------------------
module rgpe_fifo (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               wr_en,
  input  rgpe_pkg::pix_req_t wr_data,
  input  logic               rd_en,
  output rgpe_pkg::pix_req_t rd_data,
  output logic               empty,
  output logic               almost_full
);

  rgpe_pkg::pix_req_t mem_r [4];
  logic [1:0] wp_r, rp_r;
  logic [2:0] cnt_r;

  assign empty = (cnt_r == 3'd0);
  // asserts at three entries, so one entry stays spare
  assign almost_full = (cnt_r >= 3'd3);
  assign rd_data = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_en) mem_r[wp_r] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (wr_en) wp_r <= wp_r + 1'b1;
      if (rd_en) rp_r <= rp_r + 1'b1;
      cnt_r <= cnt_r + 3'(wr_en) - 3'(rd_en);
    end
  end

endmodule

/* src/rgpe_back.sv */
// ----------------------------------------------------------------------------
// rgpe_back: statistics engine
// Updates per-kind running statistics and holds the registered result.
// ----------------------------------------------------------------------------
module rgpe_back (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic signed [rgpe_pkg::ThrW-1:0] thr_und,
  input  logic signed [rgpe_pkg::ThrW-1:0] thr_vis,
  input  logic signed [rgpe_pkg::ThrW-1:0] thr_str,
  input  logic                      q_empty,
  input  rgpe_pkg::pix_req_t        q_data,
  output logic                      q_pop,
  output logic                      res_valid,
  input  logic                      res_ready,
  output rgpe_pkg::pix_res_t        res
);

  logic [rgpe_pkg::CountW-1:0] rn_r, pn_r, rm_r, pm_r, und_r, vis_r, str_r;
  logic signed [rgpe_pkg::ValW-1:0] rmin_r, rmax_r, pmin_r, pmax_r;
  logic [rgpe_pkg::CountW-1:0] n_nxt, m_nxt, und_nxt, vis_nxt, str_nxt;
  logic signed [rgpe_pkg::ValW-1:0] lo_nxt, hi_nxt, v;
  logic valid_r;
  rgpe_pkg::pix_res_t res_r, res_nxt;

  assign res_valid = valid_r;
  assign res = res_r;
  assign q_pop = !q_empty && (!valid_r || res_ready);
  assign v = q_data.value;

  always_comb begin
    und_nxt = und_r; vis_nxt = vis_r; str_nxt = str_r;
    if (q_data.kind) begin
      n_nxt = pn_r + 1'b1; m_nxt = pm_r; lo_nxt = pmin_r; hi_nxt = pmax_r;
    end else begin
      n_nxt = rn_r + 1'b1; m_nxt = rm_r; lo_nxt = rmin_r; hi_nxt = rmax_r;
    end
    if (q_data.miss) m_nxt = m_nxt + 1'b1;
    else begin
      if (v < lo_nxt) lo_nxt = v;
      if (v > hi_nxt) hi_nxt = v;
      if (!q_data.kind) begin
        if (v <= 40'(thr_und)) und_nxt = und_r + 1'b1;
        if (v >= 40'(thr_vis)) vis_nxt = vis_r + 1'b1;
        if (v >= 40'(thr_str)) str_nxt = str_r + 1'b1;
      end
    end
    res_nxt.grid_kind      = q_data.kind;
    res_nxt.pixel_value    = q_data.miss ? rgpe_pkg::NodataQ : v;
    res_nxt.is_nodata      = q_data.miss;
    res_nxt.is_last        = (n_nxt == q_data.expected);
    res_nxt.pixel_number   = n_nxt;
    res_nxt.missing_total  = m_nxt;
    res_nxt.undetect_total = q_data.kind ? '0 : und_nxt;
    res_nxt.visible_total  = q_data.kind ? '0 : vis_nxt;
    res_nxt.strong_total   = q_data.kind ? '0 : str_nxt;
    res_nxt.lowest_seen    = lo_nxt;
    res_nxt.highest_seen   = hi_nxt;
  end

  always_ff @(posedge clk) begin
    if (q_pop) res_r <= res_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      rn_r <= '0; pn_r <= '0; rm_r <= '0; pm_r <= '0;
      und_r <= '0; vis_r <= '0; str_r <= '0;
      rmin_r <= rgpe_pkg::QMax; pmin_r <= rgpe_pkg::QMax;
      rmax_r <= rgpe_pkg::QMin; pmax_r <= rgpe_pkg::QMin;
    end else begin
      if (q_pop) valid_r <= 1'b1;
      else if (res_ready) valid_r <= 1'b0;
      if (q_pop) begin
        if (q_data.kind) begin
          pn_r <= n_nxt; pm_r <= m_nxt; pmin_r <= lo_nxt; pmax_r <= hi_nxt;
        end else begin
          rn_r <= n_nxt; rm_r <= m_nxt; rmin_r <= lo_nxt; rmax_r <= hi_nxt;
          und_r <= und_nxt; vis_r <= vis_nxt; str_r <= str_nxt;
        end
      end
    end
  end

endmodule

/* src/radar_grid_pixel_extractor.sv */
// ----------------------------------------------------------------------------
// radar_grid_pixel_extractor: grid pixel capture with running statistics
// Picks the reflectivity/probability pixel runs out of a decoded stream.
// ----------------------------------------------------------------------------
// Channels: in_ takes one decoded descriptor/value request per cycle while
// in_ready is high; out_ returns one result per captured pixel; cfg_ writes
// the three Q.8 dBZ thresholds (index 0 undetect, 1 visible, 2 strong). The
// user must write them only while idle; the block does not enforce this.
// Structure: the front classifies each request in its accept cycle (header
// latch, arming, capture flags, run counts) and pushes pixel requests into a
// four-entry queue; the back pops one per cycle while out_ is not stalled,
// updates the running statistics and loads the output register.
// Path: each pixel request is queued, then popped into the output register.
// Throughput: one request per cycle sustained while out_ready is high; the
// back's single output register sets that figure. in_ready drops only when
// the queue holds three or more requests, i.e. after the receiver has
// stalled. Items that yield no result never occupy the queue.
// Reset (synchronous, rst_n low): header, counts and flags clear, min/max
// go to their extreme values, thresholds go to -40.0, 5.5 and 35.0 dBZ.
// The cfg_ port is always ready.
// ----------------------------------------------------------------------------
module radar_grid_pixel_extractor (
  input  logic            clk,
  input  logic            rst_n,
  rgpe_in_if.sink         in_ch,
  rgpe_out_if.source      out_ch,
  rgpe_cfg_if.sink        cfg_ch
);

  logic signed [rgpe_pkg::ThrW-1:0] und_r, vis_r, str_r;
  logic acc, req_valid, q_empty, q_afull, q_pop, res_valid;
  rgpe_pkg::pix_req_t req, q_data;
  rgpe_pkg::pix_res_t res;

  assign cfg_ch.ready = 1'b1;

  // threshold registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      und_r <= rgpe_pkg::UndetectReset;
      vis_r <= rgpe_pkg::VisibleReset;
      str_r <= rgpe_pkg::StrongReset;
    end else if (cfg_ch.valid) begin
      unique case (cfg_ch.index)
        rgpe_pkg::REG_UNDETECT: und_r <= cfg_ch.data;
        rgpe_pkg::REG_VISIBLE:  vis_r <= cfg_ch.data;
        rgpe_pkg::REG_STRONG:   str_r <= cfg_ch.data;
        default: ;
      endcase
    end
  end

  assign in_ch.ready = !q_afull;
  assign acc = in_ch.valid && in_ch.ready;

  rgpe_front u_front (
    .clk, .rst_n, .acc,
    .is_element (in_ch.is_element),
    .f          (in_ch.descriptor_f),
    .x          (in_ch.descriptor_x),
    .y          (in_ch.descriptor_y),
    .v          (in_ch.sample_value),
    .miss       (in_ch.value_missing),
    .req_valid, .req
  );

  rgpe_fifo u_fifo (
    .clk, .rst_n,
    .wr_en (req_valid), .wr_data (req),
    .rd_en (q_pop), .rd_data (q_data),
    .empty (q_empty), .almost_full (q_afull)
  );

  rgpe_back u_back (
    .clk, .rst_n,
    .thr_und (und_r), .thr_vis (vis_r), .thr_str (str_r),
    .q_empty, .q_data, .q_pop,
    .res_valid, .res_ready (out_ch.ready), .res
  );

  assign out_ch.valid          = res_valid;
  assign out_ch.grid_kind      = res.grid_kind;
  assign out_ch.pixel_value    = res.pixel_value;
  assign out_ch.is_nodata      = res.is_nodata;
  assign out_ch.is_last        = res.is_last;
  assign out_ch.pixel_number   = res.pixel_number;
  assign out_ch.missing_total  = res.missing_total;
  assign out_ch.undetect_total = res.undetect_total;
  assign out_ch.visible_total  = res.visible_total;
  assign out_ch.strong_total   = res.strong_total;
  assign out_ch.lowest_seen    = res.lowest_seen;
  assign out_ch.highest_seen   = res.highest_seen;

endmodule

/* dv/rgpe_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgpe_checker: pixel predictor and result comparator
// Watches the input, result and register write channels, predicts each
// captured pixel with its running statistics and compares in order.
// ----------------------------------------------------------------------------
module rgpe_checker
  import rgpe_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  rgpe_in_if.sink   in_mon,
  rgpe_out_if.sink  out_mon,
  rgpe_cfg_if.sink  cfg_mon,
  output int        mismatch_count,
  output int        pending_pixels,
  output int        pixels_seen
);

  // thresholds and extractor state
  logic signed [ThrW-1:0] thr_undetect, thr_visible, thr_strong;
  logic [DimW-1:0]        rows_q, cols_q;
  logic [CountW-1:0]      grid_total;
  logic                   armed, cap_prob, cap_refl;
  logic [CountW-1:0]      refl_n, prob_n, refl_miss, prob_miss;
  logic [CountW-1:0]      undet_n, vis_n, strong_n;
  logic signed [ValW-1:0] refl_lo, refl_hi, prob_lo, prob_hi;

  pix_res_t want_q[$];

  function automatic logic [DimW-1:0] dim_of(logic signed [ValW-1:0] q);
    logic signed [ValW-1:0] n;
    if (q < 0) return '0;
    n = q >>> 8;
    if (n > MaxDimension) n = MaxDimension;
    return n[DimW-1:0];
  endfunction

  task automatic report(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] pixel %0d: %s got %0h want %0h", $realtime, pixels_seen, what, got, want);
    mismatch_count++;
  endtask

  task automatic predict_pixel();
    logic                   f0, miss, is_prob, is_refl;
    logic signed [ValW-1:0] v;
    pix_res_t               r;
    f0   = (in_mon.descriptor_f == 2'd0);
    v    = in_mon.sample_value;
    miss = in_mon.value_missing;
    if (f0 && in_mon.descriptor_x == XDim && in_mon.descriptor_y == YRows && !miss)
      rows_q = dim_of(v);
    else if (f0 && in_mon.descriptor_x == XDim && in_mon.descriptor_y == YCols && !miss)
      cols_q = dim_of(v);
    if (grid_total == 0 && rows_q != 0 && cols_q != 0)
      grid_total = rows_q * cols_q;
    if (f0 && in_mon.descriptor_x == XRepl && in_mon.descriptor_y == YRepl && !miss) begin
      armed = (v >= 0) && grid_total != 0 && ((v >>> 8) == grid_total);
      return;
    end
    is_prob = f0 && in_mon.descriptor_x == XGrid && in_mon.descriptor_y == YProb;
    is_refl = f0 && in_mon.descriptor_x == XGrid && in_mon.descriptor_y == YRefl;
    if (armed) begin
      armed = 1'b0;
      if (is_prob) cap_prob = 1'b1;
      else if (is_refl) cap_refl = 1'b1;
    end
    r = '0;
    r.is_nodata   = miss;
    r.pixel_value = miss ? NodataQ : v;
    if (cap_prob && is_prob) begin
      if (prob_n >= grid_total) begin
        cap_prob = 1'b0;
        return;
      end
      if (miss) prob_miss++;
      else begin
        if (v < prob_lo) prob_lo = v;
        if (v > prob_hi) prob_hi = v;
      end
      prob_n++;
      r.grid_kind     = 1'b1;
      r.is_last       = (prob_n == grid_total);
      if (r.is_last) cap_prob = 1'b0;
      r.pixel_number  = prob_n;
      r.missing_total = prob_miss;
      r.lowest_seen   = prob_lo;
      r.highest_seen  = prob_hi;
      want_q.push_back(r);
      return;
    end
    if (!cap_refl || !is_refl) return;
    if (refl_n >= grid_total) begin
      cap_refl = 1'b0;
      return;
    end
    if (miss) refl_miss++;
    else begin
      if (v < refl_lo) refl_lo = v;
      if (v > refl_hi) refl_hi = v;
      if (v <= thr_undetect) undet_n++;
      if (v >= thr_visible) vis_n++;
      if (v >= thr_strong) strong_n++;
    end
    refl_n++;
    r.is_last        = (refl_n == grid_total);
    if (r.is_last) cap_refl = 1'b0;
    r.pixel_number   = refl_n;
    r.missing_total  = refl_miss;
    r.undetect_total = undet_n;
    r.visible_total  = vis_n;
    r.strong_total   = strong_n;
    r.lowest_seen    = refl_lo;
    r.highest_seen   = refl_hi;
    want_q.push_back(r);
  endtask

  task automatic compare_pixel();
    pix_res_t w;
    pixels_seen++;
    if (want_q.size() == 0) begin
      report("unexpected result", out_mon.pixel_value, 0);
      return;
    end
    w = want_q.pop_front();
    if (out_mon.grid_kind != w.grid_kind) report("grid_kind", out_mon.grid_kind, w.grid_kind);
    if (out_mon.pixel_value != w.pixel_value)
      report("pixel_value", out_mon.pixel_value, w.pixel_value);
    if (out_mon.is_nodata != w.is_nodata) report("is_nodata", out_mon.is_nodata, w.is_nodata);
    if (out_mon.is_last != w.is_last) report("is_last", out_mon.is_last, w.is_last);
    if (out_mon.pixel_number != w.pixel_number)
      report("pixel_number", out_mon.pixel_number, w.pixel_number);
    if (out_mon.missing_total != w.missing_total)
      report("missing_total", out_mon.missing_total, w.missing_total);
    if (out_mon.undetect_total != w.undetect_total)
      report("undetect_total", out_mon.undetect_total, w.undetect_total);
    if (out_mon.visible_total != w.visible_total)
      report("visible_total", out_mon.visible_total, w.visible_total);
    if (out_mon.strong_total != w.strong_total)
      report("strong_total", out_mon.strong_total, w.strong_total);
    if (out_mon.lowest_seen != w.lowest_seen)
      report("lowest_seen", out_mon.lowest_seen, w.lowest_seen);
    if (out_mon.highest_seen != w.highest_seen)
      report("highest_seen", out_mon.highest_seen, w.highest_seen);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      thr_undetect = UndetectReset;
      thr_visible  = VisibleReset;
      thr_strong   = StrongReset;
      rows_q = '0; cols_q = '0; grid_total = '0;
      armed = 1'b0; cap_prob = 1'b0; cap_refl = 1'b0;
      refl_n = '0; prob_n = '0; refl_miss = '0; prob_miss = '0;
      undet_n = '0; vis_n = '0; strong_n = '0;
      refl_lo = QMax; refl_hi = QMin; prob_lo = QMax; prob_hi = QMin;
      want_q.delete();
      mismatch_count = 0;
      pixels_seen    = 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          REG_UNDETECT: thr_undetect = cfg_mon.data;
          REG_VISIBLE:  thr_visible  = cfg_mon.data;
          REG_STRONG:   thr_strong   = cfg_mon.data;
          default: ;
        endcase
      end
      if (out_mon.valid && out_mon.ready) compare_pixel();
      if (in_mon.valid && in_mon.ready && in_mon.is_element) predict_pixel();
    end
    pending_pixels = want_q.size();
  end

endmodule

/* dv/radar_grid_pixel_extractor_test.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// radar_grid_pixel_extractor_test: stimulus and verdict for the extractor
// Builds grid headers and replicated pixel runs with random content, noise
// and broken sequences, moves the thresholds between phases and leaves the
// checking to rgpe_checker.
// ----------------------------------------------------------------------------
module radar_grid_pixel_extractor_test;
  import rgpe_pkg::*;

  localparam int WatchdogLimit = 5000;
  localparam int DrainCycles   = 8;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  always #6 clk = ~clk;

  rgpe_in_if  in_ch();
  rgpe_out_if out_ch();
  rgpe_cfg_if cfg_ch();

  int mismatch_count, pending_pixels, pixels_seen;
  int requests_sent;
  int idle_cycles;
  bit long_hold;      // receiver holds off while this is set
  bit any_fire;

  radar_grid_pixel_extractor dut (
    .clk(clk), .rst_n(rst_n), .in_ch(in_ch.sink), .out_ch(out_ch.source), .cfg_ch(cfg_ch.sink)
  );

  rgpe_checker chk (
    .clk(clk), .rst_n(rst_n), .in_mon(in_ch.sink), .out_mon(out_ch.sink), .cfg_mon(cfg_ch.sink),
    .mismatch_count(mismatch_count), .pending_pixels(pending_pixels),
    .pixels_seen(pixels_seen)
  );

  // --------------------------------------------------------------------------
  // Receiver: random stall per result, plus one long hold on request.
  // --------------------------------------------------------------------------
  initial begin
    int stall;
    out_ch.ready <= 1'b0;
    @(posedge clk iff rst_n);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        @(posedge clk);
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 7);
        repeat (stall) begin
          out_ch.ready <= 1'b0;
          @(posedge clk);
        end
        out_ch.ready <= 1'b1;
        @(posedge clk iff out_ch.valid);
      end
    end
  end

  // Watchdog: cycles with nothing accepted on any channel.
  always @(posedge clk) begin
    any_fire = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
               (cfg_ch.valid && cfg_ch.ready);
    if (!rst_n || any_fire) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchdogLimit) begin
      $display("Watchdog expired, %0d results pending", pending_pixels);
      $display("Mismatches found");
      $finish;
    end
  end

  // --------------------------------------------------------------------------
  // Sender
  // --------------------------------------------------------------------------
  bit gaps_on = 1'b1;

  // valid stays high after an accept; a gap or drain() drops it
  task automatic send_request(bit elem, logic [1:0] f, logic [5:0] x, logic [7:0] y,
                              logic signed [ValW-1:0] v, bit miss);
    int gap;
    gap = gaps_on ? (($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 7)) : 0;
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid         <= 1'b1;
    in_ch.is_element    <= elem;
    in_ch.descriptor_f  <= f;
    in_ch.descriptor_x  <= x;
    in_ch.descriptor_y  <= y;
    in_ch.sample_value  <= v;
    in_ch.value_missing <= miss;
    @(posedge clk iff in_ch.ready);
    requests_sent++;
  endtask

  task automatic send_elem(logic [5:0] x, logic [7:0] y, logic signed [ValW-1:0] v, bit miss);
    send_request(1'b1, 2'd0, x, y, v, miss);
  endtask

  function automatic logic signed [ValW-1:0] rand_value();
    logic signed [ValW-1:0] v;
    case ($urandom_range(0, 4))
      0: v = ValW'({$urandom, $urandom});                      // full range
      1: v = ValW'($signed($urandom_range(0, 30000)) - 15000); // around the thresholds
      2: v = ($urandom_range(0, 1)) ? QMax : QMin;
      default: v = ValW'($signed($urandom_range(0, 25600)) - 12800);
    endcase
    return v;
  endfunction

  // Random pixel of either kind, occasionally missing.
  task automatic send_pixel(bit prob);
    send_elem(XGrid, prob ? YProb : YRefl, rand_value(), $urandom_range(0, 7) == 0);
  endtask

  // Replication count followed by a run of pixels; extra pixels test overflow.
  task automatic send_run(int total, bit prob, int extra);
    send_elem(XRepl, YRepl, ValW'(total * 256 + $urandom_range(0, 255)), 1'b0);
    repeat (total + extra) send_pixel(prob);
  endtask

  task automatic send_noise();
    logic [ValW-1:0] raw;
    raw = ValW'({$urandom, $urandom});
    case ($urandom_range(0, 3))
      0: send_request(1'b0, 2'($urandom), 6'($urandom), 8'($urandom), raw, 1'($urandom));
      1: send_request(1'b1, 2'($urandom), 6'($urandom), 8'($urandom), raw, 1'($urandom));
      2: send_request(1'b1, 2'($urandom_range(1, 3)), XGrid,
                      ($urandom_range(0, 1)) ? YProb : YRefl, raw, 1'b0);
      default: send_elem(XRepl, YRepl, raw, 1'($urandom_range(0, 1)));
    endcase
  endtask

  // Wait until every pixel is back, then let the pipeline settle.
  task automatic drain();
    in_ch.valid <= 1'b0;
    @(posedge clk iff pending_pixels == 0);
    repeat (DrainCycles) @(posedge clk);
  endtask

  task automatic write_reg(reg_idx_t idx, logic [ThrW-1:0] data);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= data;
    @(posedge clk iff cfg_ch.ready);
  endtask

  task automatic write_thresholds(logic [ThrW-1:0] u, logic [ThrW-1:0] vis,
                                  logic [ThrW-1:0] s);
    write_reg(REG_UNDETECT, u);
    write_reg(REG_VISIBLE, vis);
    write_reg(REG_STRONG, s);
    cfg_ch.valid <= 1'b0;
  endtask

  initial begin
    int total;
    in_ch.valid <= 1'b0;
    in_ch.is_element <= 1'b0;
    in_ch.descriptor_f <= '0;
    in_ch.descriptor_x <= '0;
    in_ch.descriptor_y <= '0;
    in_ch.sample_value <= '0;
    in_ch.value_missing <= 1'b0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.index <= REG_UNDETECT;
    cfg_ch.data <= '0;
    long_hold = 1'b0;
    requests_sent = 0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ---- directed: header corner cases, before any grid is known ----
    send_elem(XGrid, YRefl, 40'sd100, 1'b0);          // unarmed pixel, ignored
    send_elem(XRepl, YRepl, 40'sd0, 1'b0);            // no total yet, never arms
    send_elem(XGrid, YRefl, 40'sd100, 1'b0);
    send_elem(XDim, YRows, 40'sd5 * 256, 1'b1);       // missing rows, ignored
    send_elem(XDim, YRows, -40'sd256, 1'b0);          // negative -> 0
    send_elem(XDim, YCols, 40'sd5000 * 256, 1'b0);    // saturates
    send_elem(XDim, YRows, 40'sd2 * 256 + 255, 1'b0); // truncates to 2, total latched
    send_elem(XDim, YCols, 40'sd3 * 256, 1'b0);       // too late to change total
    send_request(1'b0, 2'd0, XRepl, YRepl, 40'sd8192 * 256, 1'b0); // non-element
    send_elem(XRepl, YRepl, -40'sd8192 * 256, 1'b0);  // negative count
    send_elem(XGrid, YRefl, 40'sd1, 1'b0);
    // 2*4096 = 8192 pixels is too long to send in full; no run here reaches its end
    send_elem(XRepl, YRepl, 40'sd8192 * 256, 1'b1);   // missing replication disarms
    send_elem(XRepl, YRepl, 40'sd8192 * 256, 1'b0);   // arms
    send_elem(XDim, YRows, 40'sd1, 1'b0);             // other element disarms
    send_elem(XGrid, YProb, QMax, 1'b0);
    send_elem(XRepl, YRepl, 40'sd8192 * 256, 1'b0);
    send_elem(XGrid, YProb, 40'sd0, 1'b1);            // run starts on a missing pixel
    send_elem(XGrid, YProb, QMin, 1'b0);
    send_elem(XGrid, YProb, QMax, 1'b0);
    send_elem(XRepl, YRepl, 40'sd8192 * 256, 1'b0);
    send_elem(XGrid, YRefl, 40'sd0, 1'b1);            // stats before any value
    send_elem(XGrid, YRefl, -40'sd10240, 1'b0);       // exactly undetect
    send_elem(XGrid, YRefl, 40'sd1408, 1'b0);         // exactly visible
    send_elem(XGrid, YRefl, 40'sd8960, 1'b0);         // exactly strong
    drain();

    // Expected total is fixed at 8192 for the rest of the run; runs keep going
    // from the counts reached so far. Capture continues across phases.
    write_thresholds(24'h800000, 24'h7FFFFF, 24'h7FFFFF); // extremes
    for (int i = 0; i < 60; i++) send_pixel(i % 2);
    drain();
    write_thresholds(24'h7FFFFF, 24'h800000, 24'h800000);
    for (int i = 0; i < 60; i++) send_pixel(i % 2);

    // Long receiver hold while the sender keeps offering pixels.
    gaps_on = 1'b0;
    long_hold = 1'b1;
    fork
      begin
        repeat (200) @(posedge clk);
        long_hold = 1'b0;
      end
      repeat (20) send_pixel(1'b0);
    join
    gaps_on = 1'b1;
    drain();
    total = $urandom_range(0, 0); // keep declared use simple
    write_thresholds(-24'sd2000, 24'sd0, 24'sd5000);

    // Random mix: mostly pixels of the open runs, plus noise and re-arming.
    while (requests_sent < 470) begin
      case ($urandom_range(0, 9))
        0, 1:    send_noise();
        2:       send_elem(XRepl, YRepl, 40'sd8192 * 256, 1'b0);
        default: send_pixel($urandom_range(0, 1));
      endcase
      if (requests_sent % 150 == 0) begin
        drain();  // sender pauses until everything is back
        write_thresholds(ThrW'($urandom), ThrW'($urandom), ThrW'($urandom));
      end
    end
    drain();
    if (total != 0) $display("unused");

    $display("Sent %0d requests, checked %0d pixels across threshold settings,",
             requests_sent, pixels_seen);
    $display("header corner cases, arming, stalls and noise.");
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

/* files.f */
src/rgpe_pkg.sv
src/rgpe_if.sv
src/rgpe_front.sv
src/rgpe_fifo.sv
src/rgpe_back.sv
src/radar_grid_pixel_extractor.sv
dv/rgpe_checker.sv
dv/radar_grid_pixel_extractor_test.sv
